// ----- rtl/mie_pkg.sv -----
// ----------------------------------------------------------------------------
// mie_pkg
// Shared widths, controller states and the command/status bundles that join
// the modular inverse controller and datapath.
// ----------------------------------------------------------------------------
package mie_pkg;

  localparam int WORD_BITS = 32;
  localparam int CNT_W     = $clog2(WORD_BITS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WORD_BITS - 1);

  typedef logic [WORD_BITS-1:0] word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_UPDATE,
    ST_REDUCE,
    ST_FIX,
    ST_FINISH
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic div_init;
    logic div_step;
    logic update;
    logic reduce;
    logic fix;
    logic set_one;
    logic set_fail;
    logic publish;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic m_one;
    logic m_zero;
    logic a_le1;
    logic a_zero;
    logic b_zero;
    logic out_busy;
  } stat_t;

endpackage

// ----- rtl/mie_operand_if.sv -----
// ----------------------------------------------------------------------------
// mie_operand_if
// Operand channel: value and modulus with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface mie_operand_if;
  logic           valid;
  logic           ready;
  mie_pkg::word_t value;
  mie_pkg::word_t modulus;

  modport source (output valid, output value, output modulus, input ready);
  modport sink   (input valid, input value, input modulus, output ready);
endinterface

// ----- rtl/mie_result_if.sv -----
// ----------------------------------------------------------------------------
// mie_result_if
// Result channel: inverse and status with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface mie_result_if;
  logic           valid;
  logic           ready;
  mie_pkg::word_t inverse;
  logic           status;

  modport source (output valid, output inverse, output status, input ready);
  modport sink   (input valid, input inverse, input status, output ready);
endinterface

// ----- rtl/mie_ctrl.sv -----
// ----------------------------------------------------------------------------
// mie_ctrl
// Sequencer for the extended Euclid loop: checks, divide steps, coefficient
// update, final reduction and hand-off to the output register.
// ----------------------------------------------------------------------------
module mie_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  mie_pkg::stat_t                sts,
  output mie_pkg::cmd_t                 cmd
);

  mie_pkg::state_t               state, state_next;
  logic [mie_pkg::CNT_W-1:0]     cnt, cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mie_pkg::ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      mie_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = mie_pkg::ST_CHECK;
        end
      end
      mie_pkg::ST_CHECK: begin
        if (sts.m_one) begin
          cmd.set_one = 1'b1;
          state_next  = mie_pkg::ST_FINISH;
        end else if (sts.m_zero) begin
          cmd.set_fail = 1'b1;
          state_next   = mie_pkg::ST_FINISH;
        end else if (sts.a_le1) begin
          if (sts.a_zero) begin
            cmd.set_fail = 1'b1;
            state_next   = mie_pkg::ST_FINISH;
          end else begin
            state_next = mie_pkg::ST_REDUCE;
          end
        end else if (sts.b_zero) begin
          // common divisor above one
          cmd.set_fail = 1'b1;
          state_next   = mie_pkg::ST_FINISH;
        end else begin
          cmd.div_init = 1'b1;
          cnt_next     = '0;
          state_next   = mie_pkg::ST_DIV;
        end
      end
      mie_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt + 1'b1;
        if (cnt == mie_pkg::CNT_LAST) begin
          state_next = mie_pkg::ST_UPDATE;
        end
      end
      mie_pkg::ST_UPDATE: begin
        cmd.update = 1'b1;
        state_next = mie_pkg::ST_CHECK;
      end
      mie_pkg::ST_REDUCE: begin
        cmd.reduce = 1'b1;
        state_next = mie_pkg::ST_FIX;
      end
      mie_pkg::ST_FIX: begin
        cmd.fix    = 1'b1;
        state_next = mie_pkg::ST_FINISH;
      end
      mie_pkg::ST_FINISH: begin
        // hold until the output register can take the result
        if (!sts.out_busy) begin
          cmd.publish = 1'b1;
          state_next  = mie_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = mie_pkg::ST_IDLE;
      end
    endcase
  end

  a_load_only_when_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> (state == mie_pkg::ST_IDLE) && !cmd.div_step && !cmd.update)
    else $error("load issued outside idle");

  a_div_starts_at_zero: assert property (@(posedge clk) disable iff (rst)
    cmd.div_init |=> (cnt == '0) && (state == mie_pkg::ST_DIV))
    else $error("divide count not cleared on start");

  a_update_after_last_step: assert property (@(posedge clk) disable iff (rst)
    cmd.update |-> $past(cmd.div_step) && ($past(cnt) == mie_pkg::CNT_LAST))
    else $error("coefficient update before division completed");

endmodule

// ----- rtl/mie_dp.sv -----
// ----------------------------------------------------------------------------
// mie_dp
// Datapath: remainder pair, restoring divider with bit-serial quotient
// multiply, Bezout magnitudes, final reduction and output register.
// ----------------------------------------------------------------------------
module mie_dp (
  input  logic           clk,
  input  logic           rst,
  input  mie_pkg::word_t value,
  input  mie_pkg::word_t modulus,
  input  mie_pkg::cmd_t  cmd,
  output mie_pkg::stat_t sts,
  output logic           out_valid,
  input  logic           out_ready,
  output mie_pkg::word_t out_inverse,
  output logic           out_status
);

  localparam int W = mie_pkg::WORD_BITS;

  mie_pkg::word_t a, b, rem, acc, mag_prev, mag_cur, m_orig, res;
  logic           neg, res_status;

  logic [W:0]     rem_sh;
  logic           q_bit;
  mie_pkg::word_t rem_sub, acc_next, mag_sum, mag_red, mag_neg;

  // one restoring divide step; quotient bit also drives shift-add multiply
  always_comb begin
    rem_sh   = {rem, a[W-1]};
    q_bit    = (rem_sh >= {1'b0, b});
    rem_sub  = W'(rem_sh - {1'b0, b});
    acc_next = {acc[W-2:0], 1'b0} + (q_bit ? mag_prev : '0);
    mag_sum  = acc + mag_cur;
    mag_red  = mag_cur - m_orig;
    mag_neg  = m_orig - mag_cur;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      a        <= value;
      b        <= modulus;
      m_orig   <= modulus;
      mag_prev <= '0;
      mag_cur  <= W'(1);
      neg      <= 1'b0;
    end
    if (cmd.div_init) begin
      rem <= '0;
      acc <= '0;
    end
    if (cmd.div_step) begin
      rem <= q_bit ? rem_sub : rem_sh[W-1:0];
      a   <= {a[W-2:0], q_bit};
      acc <= acc_next;
    end
    if (cmd.update) begin
      // advance the pair: a <- b, b <- remainder; next magnitude |x1| + q|x0|
      a        <= b;
      b        <= rem;
      mag_prev <= mag_sum;
      mag_cur  <= mag_prev;
      neg      <= ~neg;
    end
    if (cmd.reduce && (mag_cur >= m_orig)) begin
      mag_cur <= mag_red;
    end
    if (cmd.fix) begin
      res        <= (neg && (mag_cur != '0)) ? mag_neg : mag_cur;
      res_status <= 1'b0;
    end
    if (cmd.set_one) begin
      res        <= W'(1);
      res_status <= 1'b0;
    end
    if (cmd.set_fail) begin
      res        <= '0;
      res_status <= 1'b1;
    end
    if (cmd.publish) begin
      out_inverse <= res;
      out_status  <= res_status;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.publish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_comb begin
    sts.m_one    = (m_orig == W'(1));
    sts.m_zero   = (m_orig == '0);
    sts.a_le1    = (a[W-1:1] == '0);
    sts.a_zero   = (a == '0);
    sts.b_zero   = (b == '0);
    sts.out_busy = out_valid && !out_ready;
  end

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (rst)
    $past(cmd.div_step) && !$past(rst) |-> rem < b)
    else $error("partial remainder not below divisor");

  a_fail_gives_zero: assert property (@(posedge clk) disable iff (rst)
    cmd.publish |=> out_valid && (!out_status || (out_inverse == '0)))
    else $error("no-inverse result carries nonzero value");

  a_publish_only_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.publish |-> !out_valid || out_ready)
    else $error("output register overwritten");

endmodule

// ----- rtl/modular_inverse_euclid_unit.sv -----
// ----------------------------------------------------------------------------
// modular_inverse_euclid_unit
// Modular inverse of a WORD_BITS-bit value by the extended Euclidean method.
//
// Each operand transaction (value, modulus) yields exactly one result
// transaction (inverse, status). With status 0 the inverse lies in
// [0, modulus) and value * inverse leaves remainder 1 modulo modulus; a
// modulus of one returns inverse 1. With status 1 no inverse exists (modulus
// zero, value zero, or a common divisor above one) and inverse reads 0.
// One item is worked at a time. Each Euclid iteration is one check step,
// WORD_BITS steps of the one-bit-per-cycle restoring divider (which also
// forms quotient times coefficient shift-add style), and one coefficient
// update step. For 32-bit words the worst case is 46 iterations (the first
// one only swaps the pair when value is below modulus). Results sit in an
// output register, so a new operand transaction is taken as soon as the
// previous result has been loaded there, even if the sink is stalling.
// ----------------------------------------------------------------------------
module modular_inverse_euclid_unit (
  input  logic        clk,
  input  logic        rst,
  mie_operand_if.sink operands,
  mie_result_if.source result
);

  mie_pkg::cmd_t  cmd;
  mie_pkg::stat_t sts;
  logic           in_ready;

  // Sequencer: decides each cycle's datapath operation
  mie_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (operands.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  assign operands.ready = in_ready;

  // Datapath: divider, Bezout magnitudes, result and output register
  mie_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .value       (operands.value),
    .modulus     (operands.modulus),
    .cmd         (cmd),
    .sts         (sts),
    .out_valid   (result.valid),
    .out_ready   (result.ready),
    .out_inverse (result.inverse),
    .out_status  (result.status)
  );

endmodule

// ----- bench/modular_inverse_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// modular_inverse_checker
// Watches the operand and result channels of the modular inverse unit,
// predicts the inverse and status of every accepted operand pair and checks
// each result transaction against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module modular_inverse_checker (
  input  logic          clk,
  input  logic          rst,
  mie_operand_if        operands,
  mie_result_if         result,
  output int unsigned   failures,
  output int unsigned   outstanding,
  output int unsigned   checked,
  output int unsigned   no_inverse_seen
);

  typedef struct {
    mie_pkg::word_t value;
    mie_pkg::word_t modulus;
    mie_pkg::word_t inverse;
    logic           status;
  } inverse_entry_t;

  inverse_entry_t awaited_inverses[$];

  // Extended Euclid on magnitudes; the two coefficients always have opposite
  // signs, so only the sign of the current one is tracked.
  function automatic inverse_entry_t predict_inverse(mie_pkg::word_t value,
                                                     mie_pkg::word_t modulus);
    longint unsigned a, b, q, r, prev_mag, cur_mag, next_mag;
    bit              cur_neg;
    inverse_entry_t  entry;
    entry.value   = value;
    entry.modulus = modulus;
    entry.inverse = '0;
    entry.status  = 1'b1;
    if (modulus == mie_pkg::word_t'(1)) begin
      entry.inverse = mie_pkg::word_t'(1);
      entry.status  = 1'b0;
      return entry;
    end
    if (modulus == '0) return entry;
    a        = value;
    b        = modulus;
    prev_mag = 0;
    cur_mag  = 1;
    cur_neg  = 1'b0;
    while (a > 1) begin
      // remainder hit zero with a still above one: shared divisor
      if (b == 0) return entry;
      q        = a / b;
      r        = a % b;
      a        = b;
      b        = r;
      next_mag = cur_mag + q * prev_mag;
      cur_mag  = prev_mag;
      prev_mag = next_mag;
      cur_neg  = !cur_neg;
    end
    if (a == 0) return entry;
    cur_mag = cur_mag % longint'(modulus);
    if (cur_neg && cur_mag != 0) cur_mag = longint'(modulus) - cur_mag;
    entry.inverse = mie_pkg::word_t'(cur_mag);
    entry.status  = 1'b0;
    return entry;
  endfunction

  always @(posedge clk) begin
    inverse_entry_t want;
    int unsigned    errs;
    errs = 0;
    if (rst) begin
      awaited_inverses.delete();
      failures        <= 0;
      outstanding     <= 0;
      checked         <= 0;
      no_inverse_seen <= 0;
    end else begin
      // Check the result first: it can never belong to an operand taken at
      // the same edge.
      if (result.valid && result.ready) begin
        if (awaited_inverses.size() == 0) begin
          $error("unexpected result transaction: inverse %0h status %0d",
                 result.inverse, result.status);
          errs++;
        end else begin
          want = awaited_inverses.pop_front();
          if (result.inverse !== want.inverse) begin
            $error("inverse mismatch (value %0h modulus %0h): expected %0h, actual %0h",
                   want.value, want.modulus, want.inverse, result.inverse);
            errs++;
          end
          if (result.status !== want.status) begin
            $error("status mismatch (value %0h modulus %0h): expected %0d, actual %0d",
                   want.value, want.modulus, want.status, result.status);
            errs++;
          end
          checked <= checked + 1;
          if (want.status) no_inverse_seen <= no_inverse_seen + 1;
        end
      end
      if (operands.valid && operands.ready)
        awaited_inverses.insert(awaited_inverses.size(),
                                predict_inverse(operands.value, operands.modulus));
      failures    <= failures + errs;
      outstanding <= awaited_inverses.size();
    end
  end

endmodule

// ----- bench/modular_inverse_euclid_unit_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// modular_inverse_euclid_unit_test
// Drives operand pairs into the modular inverse unit: directed corners first
// (zero and one moduli, zero value, shared divisors, value above modulus,
// Fibonacci worst cases), then a randomized mix, with random idling on both
// channels and one long result stall. A checker module predicts and compares.
// ----------------------------------------------------------------------------
module modular_inverse_euclid_unit_test;

  // Random part size; with the directed items this gives about 370 operands.
  localparam int unsigned RANDOM_ITEMS = 348;
  // Result side: one long hold-off early on, and a stretch always ready.
  localparam int unsigned HOLD_START   = 3000;
  localparam int unsigned HOLD_CYCLES  = 4000;
  localparam int unsigned SINK_STEADY_START = 60000;
  localparam int unsigned SINK_STEADY_END   = 100000;
  // Operand side: items sent back to back without gaps.
  localparam int unsigned SRC_STEADY_FIRST = 120;
  localparam int unsigned SRC_STEADY_LAST  = 180;
  // Worst-case item latency, used as the final drain.
  localparam int unsigned DRAIN_CYCLES = 1700;

  logic clk = 1'b0;
  logic rst;
  bit   source_steady;

  int unsigned failures;
  int unsigned outstanding;
  int unsigned checked;
  int unsigned no_inverse_seen;

  mie_operand_if operand_ch ();
  mie_result_if  result_ch ();

  modular_inverse_euclid_unit dut (
    .clk      (clk),
    .rst      (rst),
    .operands (operand_ch),
    .result   (result_ch)
  );

  modular_inverse_checker inverse_checker (
    .clk             (clk),
    .rst             (rst),
    .operands        (operand_ch),
    .result          (result_ch),
    .failures        (failures),
    .outstanding     (outstanding),
    .checked         (checked),
    .no_inverse_seen (no_inverse_seen)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Fibonacci number n (n >= 2); neighbors give the longest Euclid chains.
  function automatic mie_pkg::word_t fibonacci(int unsigned n);
    mie_pkg::word_t lo, hi, nxt;
    lo = '0;
    hi = mie_pkg::word_t'(1);
    repeat (n - 1) begin
      nxt = lo + hi;
      lo  = hi;
      hi  = nxt;
    end
    return hi;
  endfunction

  // Offer one operand pair and hold it until the unit takes it. Random gaps
  // go in front; junk rides on the payload while valid is low.
  task automatic send_operands(input mie_pkg::word_t value,
                               input mie_pkg::word_t modulus);
    while (!source_steady && $urandom_range(99) < 32) begin
      operand_ch.valid   <= 1'b0;
      operand_ch.value   <= $urandom();
      operand_ch.modulus <= $urandom();
      @(posedge clk);
    end
    operand_ch.valid   <= 1'b1;
    operand_ch.value   <= value;
    operand_ch.modulus <= modulus;
    @(posedge clk);
    while (!operand_ch.ready) @(posedge clk);
  endtask

  // Pick one random operand pair. About a third are full-width random; the rest
  // aim at values above small moduli, small and odd top-bit moduli, shared
  // divisors, trivial moduli and the Fibonacci worst case.
  task automatic pick_operands(output mie_pkg::word_t value,
                               output mie_pkg::word_t modulus);
    int unsigned kind, n, k;
    kind = $urandom_range(99);
    if (kind < 35) begin
      value   = $urandom();
      modulus = $urandom();
    end else if (kind < 50) begin
      // value well above modulus: the first step does the reduction
      value   = $urandom();
      modulus = $urandom_range(255, 2);
    end else if (kind < 63) begin
      modulus = $urandom_range(32'hFFFF, 2);
      value   = $urandom_range(modulus - 1, 1);
    end else if (kind < 75) begin
      // odd modulus with the top bit set, value below it
      modulus = $urandom() | 32'h8000_0001;
      value   = $urandom_range(modulus - 1, 1);
    end else if (kind < 85) begin
      // shared divisor k
      k       = $urandom_range(60, 2);
      value   = mie_pkg::word_t'(k * $urandom_range(32'hFF_FFFF, 0));
      modulus = mie_pkg::word_t'(k * $urandom_range(32'hFF_FFFF, 1));
    end else if (kind < 97) begin
      case ($urandom_range(5))
        0: begin value = '0;        modulus = $urandom(); end
        1: begin value = $urandom(); modulus = '0;        end
        2: begin value = $urandom(); modulus = mie_pkg::word_t'(1); end
        3: begin modulus = $urandom(); value = modulus;   end
        4: begin modulus = $urandom(); value = modulus - 1; end
        default: begin value = mie_pkg::word_t'(1); modulus = $urandom(); end
      endcase
    end else begin
      n = $urandom_range(47, 30);
      if ($urandom_range(1)) begin
        value   = fibonacci(n - 1);
        modulus = fibonacci(n);
      end else begin
        value   = fibonacci(n);
        modulus = fibonacci(n - 1);
      end
    end
  endtask

  // Result sink: random stalls, one long hold-off while operands keep
  // coming, and a stretch with ready always high. Cycles count from reset
  // release.
  initial begin : result_sink
    int unsigned cycle;
    cycle = 0;
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst) begin
        result_ch.ready <= 1'b0;
      end else begin
        cycle++;
        if (cycle >= HOLD_START && cycle < HOLD_START + HOLD_CYCLES)
          result_ch.ready <= 1'b0;
        else if (cycle >= SINK_STEADY_START && cycle < SINK_STEADY_END)
          result_ch.ready <= 1'b1;
        else
          result_ch.ready <= ($urandom_range(99) >= 32);
      end
    end
  end

  // Operand stimulus and verdict.
  initial begin : operand_source
    mie_pkg::word_t value, modulus;
    source_steady       = 1'b0;
    rst                <= 1'b1;
    operand_ch.valid   <= 1'b0;
    operand_ch.value   <= '0;
    operand_ch.modulus <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed corners: trivial and zero moduli, zero value, shared
    // divisors, value not below modulus, all-ones words, largest 32-bit
    // prime and the longest Euclid chains.
    send_operands(32'h0000_0000, 32'h0000_0000);
    send_operands(32'h0000_0000, 32'h0000_0001);
    send_operands(32'h0000_0005, 32'h0000_0001);
    send_operands(32'hFFFF_FFFF, 32'h0000_0001);
    send_operands(32'h0000_0000, 32'h0000_0007);
    send_operands(32'h0000_0007, 32'h0000_0000);
    send_operands(32'hFFFF_FFFF, 32'h0000_0000);
    send_operands(32'h0000_0003, 32'h0000_0007);
    send_operands(32'h0000_0007, 32'h0000_0003);
    send_operands(32'h0000_0001, 32'h0000_0002);
    send_operands(32'h0000_0002, 32'h0000_0003);
    send_operands(32'h0000_0006, 32'h0000_0009);
    send_operands(32'h0000_000A, 32'h0000_000A);
    send_operands(32'h0000_0002, 32'h0000_0004);
    send_operands(32'h0000_0001, 32'hFFFF_FFFF);
    send_operands(32'hFFFF_FFFE, 32'hFFFF_FFFF);
    send_operands(32'hFFFF_FFFF, 32'hFFFF_FFFE);
    send_operands(32'h8000_0000, 32'hFFFF_FFFF);
    send_operands(32'h0000_0003, 32'h8000_0000);
    send_operands(32'hFFFF_FFFF, 32'hFFFF_FFFB);
    send_operands(32'h0000_3039, 32'hFFFF_FFFB);
    send_operands(fibonacci(46), fibonacci(47));
    send_operands(fibonacci(47), fibonacci(46));

    for (int unsigned i = 0; i < RANDOM_ITEMS; i++) begin
      source_steady = (i >= SRC_STEADY_FIRST && i < SRC_STEADY_LAST);
      pick_operands(value, modulus);
      send_operands(value, modulus);
    end
    operand_ch.valid <= 1'b0;

    // Let the checker see the last push before polling its count.
    do @(posedge clk); while (outstanding != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Checked %0d inverse transactions, %0d of them without an inverse,",
             checked, no_inverse_seen);
    $display("covering corner moduli, shared divisors, Fibonacci chains and a %0d-cycle stall.",
             HOLD_CYCLES);
    if (failures == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

  // Watchdog: several times the slowest legal run (every item at worst-case
  // latency plus all stalls).
  initial begin : watchdog
    #100_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
